// ===== rtl/dpw_pkg.sv =====
// Shared constants, types and register codes for the depth-to-world point core.
package dpw_pkg;

  // Input field widths
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned DEPTH_BITS = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Register widths
  localparam int unsigned CENTRE_W = 16;
  localparam int unsigned INV_W    = 24;
  localparam int unsigned QUAT_W   = 16;
  localparam int unsigned TRANS_W  = 21;
  localparam int unsigned QUATP_W  = 4 * QUAT_W;
  localparam int unsigned TRANSP_W = 3 * TRANS_W;

  localparam logic [QUATP_W-1:0] QUAT_RESET = {16'h4000, 16'h0000, 16'h0000, 16'h0000};

  // Back-projection datapath
  localparam int unsigned CW4    = COORD_BITS + 4;
  localparam int unsigned DIFF_W = ((CW4 > CENTRE_W) ? CW4 : CENTRE_W) + 1;
  localparam int unsigned P_W    = DIFF_W + DEPTH_BITS;
  localparam int unsigned PI_W   = P_W + INV_W;
  localparam int unsigned FRAC_BP = 20;
  localparam int unsigned CAM_W  = 32;
  localparam int unsigned RS_W   =
    (((PI_W - FRAC_BP) > CAM_W) ? (PI_W - FRAC_BP) : CAM_W) + 1;
  localparam logic signed [PI_W-1:0] BP_HALF = PI_W'(1) << (FRAC_BP - 1);

  // Rotation datapath
  localparam int unsigned QFRAC  = 14;
  localparam int unsigned OFRAC  = 22;
  localparam int unsigned X1_W   = QUAT_W + CAM_W;
  localparam int unsigned XD_W   = X1_W + 1;
  localparam int unsigned C_W    = XD_W - QFRAC;
  localparam int unsigned X2_W   = QUAT_W + C_W;
  localparam int unsigned CC_W   = X2_W + 1;
  localparam int unsigned SUM_W  = CC_W + 2;
  localparam int unsigned RND_W  = SUM_W - OFRAC;
  localparam int unsigned OUT_W  = 24;
  localparam logic signed [XD_W-1:0]  C_HALF = XD_W'(1) << (QFRAC - 1);
  localparam logic signed [SUM_W-1:0] O_HALF = SUM_W'(1) << (OFRAC - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRINCIPAL_X = CFG_IDX_W'(0),
    REG_PRINCIPAL_Y = CFG_IDX_W'(1),
    REG_INV_FOCAL_X = CFG_IDX_W'(2),
    REG_INV_FOCAL_Y = CFG_IDX_W'(3),
    REG_ROT_QUAT    = CFG_IDX_W'(4),
    REG_TRANS_XYZ   = CFG_IDX_W'(5)
  } cfg_reg_e;

  typedef struct packed {
    logic        [CENTRE_W-1:0] cx;
    logic        [CENTRE_W-1:0] cy;
    logic        [INV_W-1:0]    ifx;
    logic        [INV_W-1:0]    ify;
    logic signed [QUAT_W-1:0]   qw;
    logic signed [QUAT_W-1:0]   qx;
    logic signed [QUAT_W-1:0]   qy;
    logic signed [QUAT_W-1:0]   qz;
    logic signed [TRANS_W-1:0]  tx;
    logic signed [TRANS_W-1:0]  ty;
    logic signed [TRANS_W-1:0]  tz;
  } cfg_t;

  typedef struct packed {
    logic signed [CAM_W-1:0] x;
    logic signed [CAM_W-1:0] y;
    logic signed [CAM_W-1:0] z;
  } cam_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] world_x;
    logic signed [OUT_W-1:0] world_y;
    logic signed [OUT_W-1:0] world_z;
  } pt_t;

endpackage

// ===== rtl/dpw_pix_if.sv =====
// Valid/ready channel carrying one depth pixel word.
interface dpw_pix_if import dpw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [DEPTH_BITS-1:0] depth;

  modport source (output valid, output col, output row, output depth, input ready);
  modport sink   (input valid, input col, input row, input depth, output ready);
endinterface

// ===== rtl/dpw_pt_if.sv =====
// Valid/ready channel carrying one world point word.
interface dpw_pt_if import dpw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] world_x;
  logic signed [OUT_W-1:0] world_y;
  logic signed [OUT_W-1:0] world_z;

  modport source (output valid, output world_x, output world_y, output world_z,
                  input ready);
  modport sink   (input valid, input world_x, input world_y, input world_z,
                  output ready);
endinterface

// ===== rtl/dpw_cfg.sv =====
// Configuration register file with write-only port.
module dpw_cfg import dpw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [CENTRE_W-1:0] cx_q, cy_q;
  logic [INV_W-1:0]    ifx_q, ify_q;
  logic [QUATP_W-1:0]  quat_q;
  logic [TRANSP_W-1:0] trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      ifx_q   <= '0;
      ify_q   <= '0;
      quat_q  <= QUAT_RESET;
      trans_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRINCIPAL_X: cx_q    <= cfg_data_i[CENTRE_W-1:0];
        REG_PRINCIPAL_Y: cy_q    <= cfg_data_i[CENTRE_W-1:0];
        REG_INV_FOCAL_X: ifx_q   <= cfg_data_i[INV_W-1:0];
        REG_INV_FOCAL_Y: ify_q   <= cfg_data_i[INV_W-1:0];
        REG_ROT_QUAT:    quat_q  <= cfg_data_i[QUATP_W-1:0];
        REG_TRANS_XYZ:   trans_q <= cfg_data_i[TRANSP_W-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  always_comb begin
    cfg_o.cx  = cx_q;
    cfg_o.cy  = cy_q;
    cfg_o.ifx = ifx_q;
    cfg_o.ify = ify_q;
    cfg_o.qw  = quat_q[4*QUAT_W-1:3*QUAT_W];
    cfg_o.qx  = quat_q[3*QUAT_W-1:2*QUAT_W];
    cfg_o.qy  = quat_q[2*QUAT_W-1:QUAT_W];
    cfg_o.qz  = quat_q[QUAT_W-1:0];
    cfg_o.tx  = trans_q[3*TRANS_W-1:2*TRANS_W];
    cfg_o.ty  = trans_q[2*TRANS_W-1:TRANS_W];
    cfg_o.tz  = trans_q[TRANS_W-1:0];
  end

endmodule

// ===== rtl/dpw_bproj.sv =====
// Three-stage pinhole back-projection: pixel and depth to camera point (Q.8).
module dpw_bproj import dpw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] col_i,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [DEPTH_BITS-1:0] depth_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cam_t                  cam_o
);

  localparam int unsigned NS = 3;

  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [P_W-1:0]    px_d, py_d, px_q, py_q;
  logic signed [PI_W-1:0]   pxi_d, pyi_d, pxi_q, pyi_q;
  logic [DEPTH_BITS-1:0]    d1_q, d2_q;
  logic [CAM_W:0]           zw;
  cam_t                     cam_d, cam_q;

  // round half away from zero by 2^FRAC_BP, then clamp to CAM_W bits
  function automatic logic signed [CAM_W-1:0] rnd_sat(input logic signed [PI_W-1:0] x);
    logic signed [PI_W-1:0] r;
    logic signed [RS_W-1:0] s;
    logic                   ovf;
    r   = x + BP_HALF - $signed(PI_W'(x[PI_W-1]));
    s   = RS_W'($signed(r[PI_W-1:FRAC_BP]));
    ovf = !((&s[RS_W-1:CAM_W-1]) || !(|s[RS_W-1:CAM_W-1]));
    if (ovf) begin
      rnd_sat = s[RS_W-1] ? {1'b1, {(CAM_W-1){1'b0}}} : {1'b0, {(CAM_W-1){1'b1}}};
    end else begin
      rnd_sat = s[CAM_W-1:0];
    end
  endfunction

  // stall chain: a stage loads when empty or when the next one moves
  always_comb begin
    adv[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = ~v_q[k] | adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign cam_o       = cam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i && (depth_i != '0);  // no measurement: dropped
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: (16*pix - centre) * d
  assign dx   = $signed(DIFF_W'({col_i, 4'b0000})) - $signed(DIFF_W'(cfg_i.cx));
  assign dy   = $signed(DIFF_W'({row_i, 4'b0000})) - $signed(DIFF_W'(cfg_i.cy));
  assign px_d = P_W'(dx) * $signed(P_W'(depth_i));
  assign py_d = P_W'(dy) * $signed(P_W'(depth_i));

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      px_q <= px_d;
      py_q <= py_d;
      d1_q <= depth_i;
    end
  end

  // stage 2: times reciprocal focal length
  assign pxi_d = PI_W'(px_q) * $signed(PI_W'(cfg_i.ifx));
  assign pyi_d = PI_W'(py_q) * $signed(PI_W'(cfg_i.ify));

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      pxi_q <= pxi_d;
      pyi_q <= pyi_d;
      d2_q  <= d1_q;
    end
  end

  // stage 3: round, saturate; Z = 256*d
  assign zw = (CAM_W + 1)'({d2_q, 8'h00});

  always_comb begin
    cam_d.x = rnd_sat(pxi_q);
    cam_d.y = rnd_sat(pyi_q);
    if (zw[CAM_W:CAM_W-1] != 2'b00) begin
      cam_d.z = {1'b0, {(CAM_W-1){1'b1}}};
    end else begin
      cam_d.z = zw[CAM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      cam_q <= cam_d;
    end
  end

`ifndef SYNTHESIS
  a_zero_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (depth_i == '0) |=> !v_q[0])
    else $error("zero-depth word entered the pipe");
  a_word_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (depth_i != '0) |=> v_q[0])
    else $error("accepted word lost at entry");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("back-projection stalled with a bubble");
  a_z_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cam_o.z[CAM_W-1])
    else $error("camera Z negative");
`endif

endmodule

// ===== rtl/dpw_rot.sv =====
// Seven-stage quaternion rotation, rounding, translation and saturation.
module dpw_rot import dpw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cam_t cam_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output pt_t  pt_o
);

  localparam int unsigned NS = 7;

  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  logic signed [CAM_W-1:0]   camv [3];
  logic signed [QUAT_W-1:0]  qv   [3];
  logic signed [TRANS_W-1:0] tv   [3];

  logic signed [X1_W-1:0]  m1a_q [3];
  logic signed [X1_W-1:0]  m1b_q [3];
  logic signed [CAM_W-1:0] cam1_q [3];
  logic signed [C_W-1:0]   c2_q  [3];
  logic signed [CAM_W-1:0] cam2_q [3];
  logic signed [X2_W-1:0]  p3a_q [3];
  logic signed [X2_W-1:0]  p3b_q [3];
  logic signed [X2_W-1:0]  wc3_q [3];
  logic signed [CAM_W-1:0] cam3_q [3];
  logic signed [SUM_W-1:0] s4_q  [3];
  logic signed [CC_W-1:0]  cc4_q [3];
  logic signed [SUM_W-1:0] r5_q  [3];
  logic signed [RND_W-1:0] o6_q  [3];
  logic signed [OUT_W-1:0] out_q [3];

  assign camv[0] = cam_i.x;
  assign camv[1] = cam_i.y;
  assign camv[2] = cam_i.z;
  assign qv[0]   = cfg_i.qx;
  assign qv[1]   = cfg_i.qy;
  assign qv[2]   = cfg_i.qz;
  assign tv[0]   = cfg_i.tx;
  assign tv[1]   = cfg_i.ty;
  assign tv[2]   = cfg_i.tz;

  always_comb begin
    adv[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = ~v_q[k] | adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // one lane per axis; cross product o[i] = a[i+1]*b[i+2] - a[i+2]*b[i+1]
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int unsigned NA = (i + 1) % 3;
    localparam int unsigned NB = (i + 2) % 3;

    logic signed [XD_W-1:0]  diff2, rr2;
    logic signed [CC_W-1:0]  cc4_d;
    logic signed [SUM_W-1:0] rr6;
    logic signed [RND_W:0]   sum7;
    logic                    ovf7;

    assign diff2 = XD_W'(m1a_q[i]) - XD_W'(m1b_q[i]);
    assign rr2   = diff2 + C_HALF - $signed(XD_W'(diff2[XD_W-1]));
    assign cc4_d = CC_W'(p3a_q[i]) - CC_W'(p3b_q[i]);
    assign rr6   = r5_q[i] + O_HALF - $signed(SUM_W'(r5_q[i][SUM_W-1]));
    assign sum7  = (RND_W + 1)'(o6_q[i]) + (RND_W + 1)'(tv[i]);
    assign ovf7  = !((&sum7[RND_W:OUT_W-1]) || !(|sum7[RND_W:OUT_W-1]));

    always_ff @(posedge clk_i) begin
      // q x v products
      if (adv[0]) begin
        m1a_q[i]  <= qv[NA] * camv[NB];
        m1b_q[i]  <= qv[NB] * camv[NA];
        cam1_q[i] <= camv[i];
      end
      // c = q x v, rounded to Q.8
      if (adv[1]) begin
        c2_q[i]   <= rr2[XD_W-1:QFRAC];
        cam2_q[i] <= cam1_q[i];
      end
      // q x c and w*c products
      if (adv[2]) begin
        p3a_q[i]  <= qv[NA] * c2_q[NB];
        p3b_q[i]  <= qv[NB] * c2_q[NA];
        wc3_q[i]  <= cfg_i.qw * c2_q[i];
        cam3_q[i] <= cam2_q[i];
      end
      if (adv[3]) begin
        s4_q[i]  <= (SUM_W'(cam3_q[i]) <<< QFRAC) + (SUM_W'(wc3_q[i]) <<< 1);
        cc4_q[i] <= cc4_d;
      end
      if (adv[4]) begin
        r5_q[i] <= s4_q[i] + (SUM_W'(cc4_q[i]) <<< 1);
      end
      // back to whole depth units
      if (adv[5]) begin
        o6_q[i] <= rr6[SUM_W-1:OFRAC];
      end
      // translate, saturate to the output range
      if (adv[6]) begin
        if (ovf7) begin
          out_q[i] <= sum7[RND_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
          out_q[i] <= sum7[OUT_W-1:0];
        end
      end
    end
  end

  assign pt_o.world_x = out_q[0];
  assign pt_o.world_y = out_q[1];
  assign pt_o.world_z = out_q[2];

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("rotation stalled with a bubble");
`endif

endmodule

// ===== rtl/depth_pixel_to_world_point_core.sv =====
// Top level: depth pixel to world point, back-projection plus rigid transform.
// Throughput: one word per cycle, set by the ten-stage pipe (3 back-projection,
//   7 rotation); pix_i.ready falls only with every stage full and pt_o stalled.
// Reset (rst_ni, async, active low) empties the pipe and returns the registers
//   to zero centre, zero focal reciprocals, identity rotation, zero translation.
module depth_pixel_to_world_point_core import dpw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dpw_pix_if.sink               pix_i,
  dpw_pt_if.source              pt_o
);

  cfg_t cfg;

  // back-projection to rotation hand-off
  logic cam_valid;
  logic cam_ready;
  cam_t cam;

  logic pix_ready;
  logic pt_valid;
  pt_t  pt;

  // Registers must only be written with the pipe empty (the core does not
  // enforce this), so stages read them directly without shadow copies.
  dpw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // X = (u-cx)*d/fx, Y = (v-cy)*d/fy, Z = d, all in Q.8 depth units;
  // zero-depth words are taken and dropped at entry
  dpw_bproj u_bproj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_ready),
    .col_i       (pix_i.col),
    .row_i       (pix_i.row),
    .depth_i     (pix_i.depth),
    .out_valid_o (cam_valid),
    .out_ready_i (cam_ready),
    .cam_o       (cam)
  );

  // v' = v + 2w(q x v) + 2 q x (q x v), rounded, translated, saturated;
  // the last stage is the output register
  dpw_rot u_rot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (cam_valid),
    .in_ready_o  (cam_ready),
    .cam_i       (cam),
    .out_valid_o (pt_valid),
    .out_ready_i (pt_o.ready),
    .pt_o        (pt)
  );

  assign pix_i.ready  = pix_ready;
  assign pt_o.valid   = pt_valid;
  assign pt_o.world_x = pt.world_x;
  assign pt_o.world_y = pt.world_y;
  assign pt_o.world_z = pt.world_z;

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the depth pixel to world point core: random and corner stimulus, scoreboard.
module tb_top;
  import dpw_pkg::*;

  // Spare register indexes; writes to these must leave every register alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

  // Pipe is ten stages deep; allow a few spare cycles after the last point
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam longint LIMIT_TIME = 64'd8_000_000;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [DEPTH_BITS-1:0] depth;
  } pixel_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dpw_pix_if pix_if ();
  dpw_pt_if  pt_if ();

  depth_pixel_to_world_point_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .pt_o       (pt_if)
  );

  // Scoreboard state: pixels waiting to be driven, points waiting to come out,
  // and our own copy of the camera pose registers.
  pixel_t      pending_pixels[$];
  pt_t         due_points[$];
  cfg_t        pose;
  int unsigned mismatches = 0;

  // Idle control. While calm_* is set that side never idles, which gives
  // stretches of back-to-back words between the gappy ones.
  bit          calm_src = 1'b0;
  bit          calm_snk = 1'b0;
  int unsigned gap_left;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the pipe hangs or points go missing
  initial begin
    #(LIMIT_TIME);
    $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 149) == 0) calm_src <= ~calm_src;
    if ($urandom_range(0, 149) == 0) calm_snk <= ~calm_snk;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("tb_top: mismatch at %0t: %s", $time, what);
  endtask

  // Mostly no idle, some short gaps, the odd long one
  function automatic int unsigned idle_length(input bit calm);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Divide by 2^s, rounding half away from zero
  function automatic longint round_shift(input longint x, input int unsigned s);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + (longint'(1) <<< (s - 1))) >>> s;
    return (x < 0) ? -m : m;
  endfunction

  // (16*pix - centre) * depth is Q.4; times the Q0.24 reciprocal gives Q.28,
  // rounded half away from zero to Q.8, then held inside a signed 32-bit camera coordinate.
  function automatic longint backproject_axis(input longint pix, input longint centre,
                                              input longint depth, input longint recip);
    longint p;
    longint m;
    longint r;
    p = (pix * 16 - centre) * depth;
    m = (p < 0) ? -p : p;
    r = (m * recip + (longint'(1) <<< (FRAC_BP - 1))) >>> FRAC_BP;
    if (p < 0) r = -r;
    return clamp_range(r, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1);
  endfunction

  // World point for one pixel under the current pose
  function automatic pt_t project_pixel(input logic [COORD_BITS-1:0] u,
                                        input logic [COORD_BITS-1:0] v,
                                        input logic [DEPTH_BITS-1:0] d);
    longint cam[3];
    longint q[3];
    longint c[3];
    longint cc[3];
    longint t[3];
    longint o[3];
    longint w;
    longint acc;
    pt_t    pt;
    cam[0] = backproject_axis(u, pose.cx, d, pose.ifx);
    cam[1] = backproject_axis(v, pose.cy, d, pose.ify);
    cam[2] = longint'(d) * 256;
    w    = $signed(pose.qw);
    q[0] = $signed(pose.qx);
    q[1] = $signed(pose.qy);
    q[2] = $signed(pose.qz);
    t[0] = $signed(pose.tx);
    t[1] = $signed(pose.ty);
    t[2] = $signed(pose.tz);
    // q x cam in Q.22, brought back to Q.8
    c[0] = q[1] * cam[2] - q[2] * cam[1];
    c[1] = q[2] * cam[0] - q[0] * cam[2];
    c[2] = q[0] * cam[1] - q[1] * cam[0];
    for (int i = 0; i < 3; i++) c[i] = round_shift(c[i], QFRAC);
    cc[0] = q[1] * c[2] - q[2] * c[1];
    cc[1] = q[2] * c[0] - q[0] * c[2];
    cc[2] = q[0] * c[1] - q[1] * c[0];
    for (int i = 0; i < 3; i++) begin
      acc  = cam[i] * 16384 + 2 * w * c[i] + 2 * cc[i];
      acc  = round_shift(acc, OFRAC) + t[i];
      o[i] = clamp_range(acc, -64'sd8388608, 64'sd8388607);
    end
    pt.world_x = o[0][OUT_W-1:0];
    pt.world_y = o[1][OUT_W-1:0];
    pt.world_z = o[2][OUT_W-1:0];
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: takes words off pending_pixels, predicts on acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t nxt;
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      pix_if.col   <= '0;
      pix_if.row   <= '0;
      pix_if.depth <= '0;
      gap_left     <= 0;
    end else begin
      // zero depth is swallowed by the core, so nothing is expected for it
      if (pix_if.valid && pix_if.ready && pix_if.depth != '0)
        due_points.push_back(project_pixel(pix_if.col, pix_if.row, pix_if.depth));
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          pix_if.valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          nxt          = pending_pixels.pop_front();
          pix_if.col   <= nxt.col;
          pix_if.row   <= nxt.row;
          pix_if.depth <= nxt.depth;
          pix_if.valid <= 1'b1;
          gap_left     <= idle_length(calm_src);
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Point monitor: random back-pressure, in-order compare per field
  // ---------------------------------------------------------------------------

  task automatic check_point();
    pt_t want;
    if (due_points.size() == 0) begin
      flag_mismatch($sformatf("point (%0d,%0d,%0d) with none expected",
                              pt_if.world_x, pt_if.world_y, pt_if.world_z));
    end else begin
      want = due_points.pop_front();
      if (pt_if.world_x !== want.world_x)
        flag_mismatch($sformatf("world_x %0d, want %0d", pt_if.world_x, want.world_x));
      if (pt_if.world_y !== want.world_y)
        flag_mismatch($sformatf("world_y %0d, want %0d", pt_if.world_y, want.world_y));
      if (pt_if.world_z !== want.world_z)
        flag_mismatch($sformatf("world_z %0d, want %0d", pt_if.world_z, want.world_z));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_if.ready <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (pt_if.valid && pt_if.ready) check_point();
      if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        pt_if.ready <= 1'b0;
      end else begin
        pt_if.ready <= 1'b1;
        stall_left  <= idle_length(calm_snk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and stimulus
  // ---------------------------------------------------------------------------

  // Drive one write; the core takes it on the next edge. Caller drops we.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_PRINCIPAL_X: pose.cx = val[CENTRE_W-1:0];
      REG_PRINCIPAL_Y: pose.cy = val[CENTRE_W-1:0];
      REG_INV_FOCAL_X: pose.ifx = val[INV_W-1:0];
      REG_INV_FOCAL_Y: pose.ify = val[INV_W-1:0];
      REG_ROT_QUAT:    {pose.qw, pose.qx, pose.qy, pose.qz} = val[QUATP_W-1:0];
      REG_TRANS_XYZ:   {pose.tx, pose.ty, pose.tz} = val[TRANSP_W-1:0];
      default: ;
    endcase
  endtask

  // Load all six registers; unused upper data bits carry junk
  task automatic apply_pose(input cfg_t p);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_PRINCIPAL_X, {junk[63:16], p.cx});
    write_reg(REG_PRINCIPAL_Y, {junk[47:0], p.cy});
    write_reg(REG_INV_FOCAL_X, {junk[39:0], p.ifx});
    write_reg(REG_INV_FOCAL_Y, {junk[63:24], p.ify});
    write_reg(REG_ROT_QUAT, {p.qw, p.qx, p.qy, p.qz});
    write_reg(REG_TRANS_XYZ, {junk[0], p.tx, p.ty, p.tz});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // kind 0: plausible camera, unit rotation, small shift
  // kind 1: every register bit random (non-unit quaternion, saturation)
  // kind 2: plausible camera, unit rotation, any shift
  task automatic randomise_pose(input int unsigned kind);
    logic [$bits(cfg_t)-1:0] raw;
    cfg_t p;
    real  ax;
    real  ay;
    real  az;
    real  nrm;
    real  ang;
    real  hs;
    raw = $bits(cfg_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom});
    p   = raw;
    if (kind != 1) begin
      p.cx  = CENTRE_W'($urandom_range(0, 65535));
      p.cy  = CENTRE_W'($urandom_range(0, 65535));
      // focal lengths of roughly 200 to 2000 pixels
      p.ifx = INV_W'($urandom_range(8389, 83886));
      p.ify = INV_W'($urandom_range(8389, 83886));
      ax  = real'($urandom_range(0, 2000)) - 1000.0;
      ay  = real'($urandom_range(0, 2000)) - 1000.0;
      az  = real'($urandom_range(0, 2000)) - 1000.0;
      nrm = $sqrt(ax * ax + ay * ay + az * az);
      if (nrm < 1.0) begin
        ax  = 1.0;
        nrm = 1.0;
      end
      ang  = real'($urandom_range(0, 62831)) / 10000.0;
      hs   = $sin(ang / 2.0) / nrm;
      p.qw = QUAT_W'(int'(16384.0 * $cos(ang / 2.0)));
      p.qx = QUAT_W'(int'(16384.0 * hs * ax));
      p.qy = QUAT_W'(int'(16384.0 * hs * ay));
      p.qz = QUAT_W'(int'(16384.0 * hs * az));
    end
    if (kind == 0) begin
      p.tx = TRANS_W'(int'($urandom_range(0, 8000)) - 4000);
      p.ty = TRANS_W'(int'($urandom_range(0, 8000)) - 4000);
      p.tz = TRANS_W'(int'($urandom_range(0, 8000)) - 4000);
    end
    apply_pose(p);
  endtask

  // Field extremes and alternating bit patterns, zero depth included
  task automatic queue_corner_pixels();
    pending_pixels.push_back('{12'd0,    12'd0,    16'd0});
    pending_pixels.push_back('{12'd4095, 12'd4095, 16'd0});
    pending_pixels.push_back('{12'd0,    12'd0,    16'd1});
    pending_pixels.push_back('{12'd4095, 12'd4095, 16'd1});
    pending_pixels.push_back('{12'd0,    12'd4095, 16'hFFFF});
    pending_pixels.push_back('{12'd4095, 12'd0,    16'hFFFF});
    pending_pixels.push_back('{12'd320,  12'd240,  16'd1000});
    pending_pixels.push_back('{12'd2048, 12'd2048, 16'h8000});
    pending_pixels.push_back('{12'd1234, 12'd567,  16'hFFFF});
    pending_pixels.push_back('{12'hAAA,  12'h555,  16'hAAAA});
    pending_pixels.push_back('{12'h555,  12'hAAA,  16'h5555});
  endtask

  task automatic queue_random_pixels(input int unsigned n);
    pixel_t      px;
    int unsigned pick;
    repeat (n) begin
      px.col = COORD_BITS'($urandom);
      px.row = COORD_BITS'($urandom);
      pick   = $urandom_range(0, 99);
      if (pick < 10)      px.depth = '0;
      else if (pick < 75) px.depth = DEPTH_BITS'($urandom_range(200, 8000));
      else if (pick < 80) px.depth = '1;
      else                px.depth = DEPTH_BITS'($urandom);
      pending_pixels.push_back(px);
    end
  endtask

  // Hold off until every word has gone in and every point has come out,
  // then let any dropped zero-depth words clear the pipe as well.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || pix_if.valid || due_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    pose         = '0;
    {pose.qw, pose.qx, pose.qy, pose.qz} = QUAT_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset pose: zero reciprocals, so X = Y = 0 and Z is the depth
    pending_pixels.push_back('{12'd0,    12'd0,    16'd0});
    pending_pixels.push_back('{12'd4095, 12'd4095, 16'hFFFF});
    pending_pixels.push_back('{12'd100,  12'd200,  16'd1234});
    wait_drained();

    // VGA-like camera, identity rotation written explicitly, small shift
    apply_pose(cfg_t'({16'h1400, 16'h0F00, 24'd31957, 24'd31957, QUAT_RESET,
                       21'd100, 21'h1FFFCE, 21'd2000}));
    queue_corner_pixels();
    wait_drained();

    // Top extremes: camera coords saturate, non-unit quaternion, shift at
    // both limits. Spare indexes written first must change nothing.
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, '1);
    apply_pose(cfg_t'({16'hFFFF, 16'h0000, 24'hFFFFFF, 24'hFFFFFF,
                       64'h7FFF_8000_7FFF_8000, 21'h0FFFFF, 21'h100000, 21'h0FFFFF}));
    queue_corner_pixels();
    wait_drained();

    // Bottom extremes: most negative quaternion, tiny reciprocals
    apply_pose(cfg_t'({16'h0000, 16'hFFFF, 24'h000000, 24'h000001,
                       64'h8000_8000_8000_8000, 21'h100000, 21'h0FFFFF, 21'h100000}));
    queue_random_pixels(40);
    wait_drained();

    // Random poses; one phase also pauses halfway with the pipe drained
    for (int unsigned ph = 0; ph < 6; ph++) begin
      randomise_pose(ph % 3);
      if (ph == 3) begin
        queue_random_pixels(65);
        wait_drained();
        queue_random_pixels(65);
      end else begin
        queue_random_pixels(130);
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
